[rtl/core/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, sequencer state type and datapath functions for the
// MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned StateDepth  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned IdxWidth    = $clog2(StateDepth);

  localparam logic [WordWidth-1:0] MtMatrix    = 32'h9908_b0df;
  localparam logic [WordWidth-1:0] MtUpper     = 32'h8000_0000;
  localparam logic [WordWidth-1:0] MtLower     = 32'h7fff_ffff;
  localparam logic [WordWidth-1:0] MtMult      = 32'd1812433253;
  localparam logic [WordWidth-1:0] MtTmaskB    = 32'h9d2c_5680;
  localparam logic [WordWidth-1:0] MtTmaskC    = 32'hefc6_0000;
  localparam logic [WordWidth-1:0] MtSeedReset = 32'd5489;

  localparam logic [IdxWidth-1:0] IdxLast   = IdxWidth'(StateDepth - 1);
  localparam logic [IdxWidth-1:0] FarOffset = IdxWidth'(TwistOffset);

  typedef logic [WordWidth-1:0] word_t;
  typedef logic [IdxWidth-1:0]  idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_CALC
  } seq_state_e;

  // One step of the seeding recurrence, low 32 bits kept
  function automatic word_t fill_next(word_t prev, idx_t i);
    word_t x;
    word_t prod;
    x    = prev ^ (prev >> 30);
    prod = word_t'(MtMult * x);
    return prod + word_t'(i);
  endfunction

  // Twist one word from the current, next and far entries
  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t mix;
    y   = (cur & MtUpper) | (nxt & MtLower);
    mix = y[0] ? MtMatrix : '0;
    return far ^ (y >> 1) ^ mix;
  endfunction

  // Output tempering
  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MtTmaskB);
    y = y ^ ((y << 15) & MtTmaskC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[rtl/core/mersenne_twister_generator_top.sv]
// ----------------------------------------------------------------------------
// mersenne_twister_generator_top
// MT19937 32-bit generator: each request with draw_request set returns the
// next tempered word; the 624-word state lives in one RAM.
// ----------------------------------------------------------------------------
// A draw runs through the sequencer states: the request is taken in the idle
// state, then the current, next and far state words are read one after
// another through the single read port of the state RAM, and in the last
// state, once the output register is free, the twisted word is written back
// and its tempered value is loaded into the output register. The state is
// twisted one word per draw, in place, in the same order as a full-block
// twist. The first draw after reset or after a seed write first fills the
// state from the seed, one word per cycle through the seeding multiplier.
// A request with draw_request clear is taken and returns nothing. The next
// request is taken while a result still waits in the output register.
module mersenne_twister_generator_top
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Draw requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] draw_request, [7:1] zero
  // Random words
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] random_word
  // Seed register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  seq_state_e state_q, state_d;

  word_t seed_q;
  logic  uninit_q;
  idx_t  idx_q;
  idx_t  fill_cnt_q;
  word_t prev_q;
  word_t cur_q;
  word_t nxt_q;
  word_t out_q;
  logic  out_valid_q;

  logic  req_accept;
  logic  draw;
  logic  out_free;
  logic  fill_last;

  logic  ram_we;
  idx_t  ram_waddr;
  word_t ram_wdata;
  logic  ram_re;
  idx_t  ram_raddr;
  word_t ram_rdata;

  idx_t               idx_nxt;
  logic [IdxWidth:0]  far_sum;
  idx_t               idx_far;
  word_t              fill_word;
  word_t              twisted;

  // Handshake and decode
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign req_accept      = s_axis_tvalid_i & s_axis_tready_o;
  assign draw            = s_axis_tdata_i[0];
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign fill_last       = (fill_cnt_q == IdxLast);

  // Neighbor addresses of the current word
  assign idx_nxt = (idx_q == IdxLast) ? '0 : idx_q + idx_t'(1);
  assign far_sum = {1'b0, idx_q} + {1'b0, FarOffset};
  assign idx_far = (far_sum >= (IdxWidth+1)'(StateDepth))
                   ? idx_t'(far_sum - (IdxWidth+1)'(StateDepth))
                   : idx_t'(far_sum);

  // Seeding and twist datapath
  assign fill_word = (fill_cnt_q == '0) ? seed_q : fill_next(prev_q, fill_cnt_q);
  assign twisted   = twist_word(cur_q, nxt_q, ram_rdata);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_accept && draw) begin
          state_d = uninit_q ? ST_FILL : ST_RD_CUR;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_d = ST_RD_CUR;
        end
      end
      ST_RD_CUR: state_d = ST_RD_NXT;
      ST_RD_NXT: state_d = ST_RD_FAR;
      ST_RD_FAR: state_d = ST_CALC;
      ST_CALC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = twisted;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    unique case (state_q)
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt_q;
        ram_wdata = fill_word;
      end
      ST_RD_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      ST_RD_NXT: begin
        ram_re    = 1'b1;
        ram_raddr = idx_nxt;
      end
      ST_RD_FAR: begin
        ram_re    = 1'b1;
        ram_raddr = idx_far;
      end
      ST_CALC: begin
        ram_we    = out_free;
        ram_waddr = idx_q;
        ram_wdata = twisted;
      end
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  // Sequencer and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= MtSeedReset;
      uninit_q    <= 1'b1;
      idx_q       <= '0;
      fill_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Hold seed, mark state for refill on write
      if (cfg_we_i) begin
        seed_q   <= cfg_wdata_i;
        uninit_q <= 1'b1;
      end else if (state_q == ST_FILL && fill_last) begin
        uninit_q <= 1'b0;
      end

      // Advance fill counter, restart block after fill
      if (state_q == ST_FILL) begin
        fill_cnt_q <= fill_last ? '0 : fill_cnt_q + idx_t'(1);
        if (fill_last) begin
          idx_q <= '0;
        end
      end else if (state_q == ST_CALC && out_free) begin
        idx_q <= idx_nxt;
      end

      // Output register valid
      if (state_q == ST_CALC && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      prev_q <= fill_word;
    end
    if (state_q == ST_RD_NXT) begin
      cur_q <= ram_rdata;
    end
    if (state_q == ST_RD_FAR) begin
      nxt_q <= ram_rdata;
    end
    if (state_q == ST_CALC && out_free) begin
      out_q <= temper(twisted);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // State memory
  mtg_ram #(
    .Width(WordWidth),
    .Depth(StateDepth)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

[rtl/core/mtg_ram.sv]
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data that holds while no read is requested.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
